// ===== rtl/skf_pkg.sv =====
// Shared types and constants for the scalar Kalman filter block.
// No dependencies; imported by the divider, the multiplier and the top level.
`timescale 1ns / 1ps
`default_nettype none

package skf_pkg;

    localparam int DATA_W      = 32;
    localparam int GAIN_W      = 17;
    localparam int REG_INDEX_W = 2;

    // Divider geometry: the quotient is at most one in Q0.16, so 17 bits.
    localparam int DIV_STEPS   = GAIN_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);
    localparam int NUMER_W     = DATA_W + 16 + 1;
    localparam int DENOM_W     = DATA_W + 1;

    // Shared multiplier operand widths.
    localparam int MUL_A_W     = DATA_W + 2;
    localparam int MUL_B_W     = GAIN_W + 1;
    localparam int MUL_P_W     = MUL_A_W + MUL_B_W;

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(65536);

    localparam logic [DATA_W-1:0] PROCESS_NOISE_RESET     = DATA_W'(1311);
    localparam logic [DATA_W-1:0] MEASUREMENT_NOISE_RESET = DATA_W'(29098);

    localparam logic [REG_INDEX_W-1:0] REG_PROCESS_NOISE     = REG_INDEX_W'(0);
    localparam logic [REG_INDEX_W-1:0] REG_MEASUREMENT_NOISE = REG_INDEX_W'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIV_START,
        S_DIV_WAIT,
        S_MUL_X,
        S_MUL_P,
        S_UPDATE,
        S_OUT
    } state_t;

    typedef struct packed {
        logic busy;
    } div_status_t;

endpackage

`default_nettype wire

// ===== rtl/skf_div.sv =====
// Restoring divider for the Kalman gain, one quotient bit per cycle.
// Depends on skf_pkg for widths and the status struct.
`timescale 1ns / 1ps
`default_nettype none

module skf_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [skf_pkg::NUMER_W-1:0] numer,
    input  wire logic [skf_pkg::DENOM_W-1:0] denom,
    output skf_pkg::div_status_t             status,
    output logic      [skf_pkg::GAIN_W-1:0]  quotient
);
    import skf_pkg::*;

    localparam int LOW_W = DIV_STEPS;

    logic [DIV_CNT_W-1:0] count_reg, count_next;
    logic [DENOM_W-1:0]   rem_reg, rem_next;
    logic [LOW_W-1:0]     bits_reg, bits_next;
    logic [GAIN_W-1:0]    quo_reg, quo_next;
    logic [DENOM_W-1:0]   denom_reg, denom_next;
    logic [DENOM_W:0]     trial;
    logic                 fits;

    // The top bits of the numerator are already below the divisor, since the
    // quotient is known to fit in the gain width; only the low bits iterate.
    always_comb begin
        trial      = {rem_reg, bits_reg[LOW_W-1]};
        fits       = trial >= {1'b0, denom_reg};
        count_next = count_reg;
        rem_next   = rem_reg;
        bits_next  = bits_reg;
        quo_next   = quo_reg;
        denom_next = denom_reg;
        if (start) begin
            count_next = DIV_CNT_W'(DIV_STEPS);
            rem_next   = DENOM_W'(numer[NUMER_W-1:LOW_W]);
            bits_next  = numer[LOW_W-1:0];
            quo_next   = '0;
            denom_next = denom;
        end else if (count_reg != '0) begin
            count_next = count_reg - DIV_CNT_W'(1);
            rem_next   = fits ? DENOM_W'(trial - {1'b0, denom_reg}) : trial[DENOM_W-1:0];
            bits_next  = {bits_reg[LOW_W-2:0], 1'b0};
            quo_next   = {quo_reg[GAIN_W-2:0], fits};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
        rem_reg   <= rem_next;
        bits_reg  <= bits_next;
        quo_reg   <= quo_next;
        denom_reg <= denom_next;
    end

    assign status.busy = count_reg != '0;
    assign quotient    = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/skf_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on skf_pkg for operand widths.
`timescale 1ns / 1ps
`default_nettype none

module skf_mul (
    input  wire logic                               aclk,
    input  wire logic signed [skf_pkg::MUL_A_W-1:0] op_a,
    input  wire logic signed [skf_pkg::MUL_B_W-1:0] op_b,
    output logic signed      [skf_pkg::MUL_P_W-1:0] product
);
    import skf_pkg::*;

    logic signed [MUL_P_W-1:0] product_reg, product_next;

    always_comb begin
        product_next = MUL_P_W'(op_a) * MUL_P_W'(op_b);
    end

    always_ff @(posedge aclk) begin
        product_reg <= product_next;
    end

    assign product = product_reg;

endmodule

`default_nettype wire

// ===== rtl/scalar_kalman_filter.sv =====
// Top level of the scalar Kalman filter: sequencer, state and I/O registers.
// Depends on skf_pkg, skf_div and skf_mul.
//
// Usage: each measurement word (signed Q16.16) enters on the s_ channel with
// a valid/ready handshake. The block predicts the variance p + Q (saturating),
// forms the gain p / (p + R) in Q0.16 with a restoring divider that yields one
// quotient bit per cycle, and then runs two products through one shared
// multiplier: the estimate step and the new variance.
// The result word (estimate and gain) leaves on the m_ channel from an output
// register. A word is accepted only while the sequencer is idle, so one word is
// in work at a time. The divider's 17 steps take the bulk of the time from
// acceptance to m_valid; a new word can be taken in the cycle after the
// result is loaded.
// If the receiver stalls, the finished result holds in the output register and
// the block still takes and computes the next word; that word then waits in
// its final step until the output register is free.
// Reset (aresetn low, synchronous) clears the estimate and the variance to
// zero, sets Q to 1311 and R to 29098, and empties the output register.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// are meant for idle periods; unknown indexes are ignored.
`timescale 1ns / 1ps
`default_nettype none

module scalar_kalman_filter (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic signed [skf_pkg::DATA_W-1:0] s_measurement,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic signed [skf_pkg::DATA_W-1:0]    m_estimate,
    output logic [skf_pkg::GAIN_W-1:0]           m_gain,
    input  wire logic                            cfg_we,
    input  wire logic [skf_pkg::REG_INDEX_W-1:0] cfg_index,
    input  wire logic [skf_pkg::DATA_W-1:0]      cfg_data
);
    import skf_pkg::*;

    state_t state_reg, state_next;

    // Configuration and filter state.
    logic [DATA_W-1:0]        q_reg, r_reg;
    logic signed [DATA_W-1:0] estimate_reg;
    logic [DATA_W-1:0]        variance_reg;

    // Per-word working registers.
    logic signed [DATA_W-1:0] z_reg;
    logic [DATA_W-1:0]        pm_reg;
    logic [DENOM_W-1:0]       den_reg;
    logic signed [DATA_W:0]   diff_reg;
    logic [GAIN_W-1:0]        gain_reg;
    logic signed [DATA_W-1:0] x_new_reg;
    logic [DATA_W-1:0]        p_new_reg;

    // Output register.
    logic                     m_valid_reg;
    logic signed [DATA_W-1:0] m_estimate_reg;
    logic [GAIN_W-1:0]        m_gain_reg;

    // Sequencer outputs.
    logic div_start;
    logic load_out;
    logic out_free;

    // Datapath nets.
    logic [DATA_W:0]           pm_sum;
    logic [DATA_W-1:0]         pm_sat;
    logic [NUMER_W-1:0]        numer;
    div_status_t               div_status;
    logic [GAIN_W-1:0]         quotient;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] product;
    logic signed [MUL_P_W-1:0] rounded;
    logic signed [MUL_P_W-1:0] shifted;
    logic signed [DATA_W+1:0]  x_sum;

    assign out_free = !m_valid_reg || m_ready;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:      if (s_valid) state_next = S_PREP;
            S_PREP:      state_next = S_DIV_START;
            S_DIV_START: state_next = S_DIV_WAIT;
            S_DIV_WAIT:  if (!div_status.busy) state_next = S_MUL_X;
            S_MUL_X:     state_next = S_MUL_P;
            S_MUL_P:     state_next = S_UPDATE;
            S_UPDATE:    state_next = S_OUT;
            S_OUT:       if (out_free) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs, including the shared multiplier's operand select.
    always_comb begin
        s_ready   = 1'b0;
        div_start = 1'b0;
        load_out  = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        unique case (state_reg)
            S_IDLE:      s_ready = 1'b1;
            S_PREP:      ;
            S_DIV_START: div_start = 1'b1;
            S_DIV_WAIT:  ;
            S_MUL_X: begin
                mul_a = MUL_A_W'(diff_reg);
                mul_b = $signed({1'b0, gain_reg});
            end
            S_MUL_P: begin
                mul_a = $signed({2'b00, pm_reg});
                mul_b = $signed({1'b0, GAIN_W'(GAIN_ONE - gain_reg)});
            end
            S_UPDATE:    ;
            S_OUT:       load_out = out_free;
            default:     ;
        endcase
    end

    // Predicted variance, saturated at the 32-bit maximum.
    assign pm_sum = {1'b0, variance_reg} + {1'b0, q_reg};
    assign pm_sat = pm_sum[DATA_W] ? '1 : pm_sum[DATA_W-1:0];

    // Gain numerator with half the denominator added for rounding.
    assign numer = NUMER_W'({pm_reg, 16'h0000}) + NUMER_W'(den_reg[DENOM_W-1:1]);

    // Round the product to nearest and floor-divide by 65536.
    assign rounded = product + MUL_P_W'(32768);
    assign shifted = rounded >>> 16;
    assign x_sum   = (DATA_W+2)'(estimate_reg) + shifted[DATA_W+1:0];

    skf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .numer    (numer),
        .denom    (den_reg),
        .status   (div_status),
        .quotient (quotient)
    );

    skf_mul u_mul (
        .aclk    (aclk),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (product)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            q_reg        <= PROCESS_NOISE_RESET;
            r_reg        <= MEASUREMENT_NOISE_RESET;
            estimate_reg <= '0;
            variance_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_PROCESS_NOISE:     q_reg <= cfg_data;
                    REG_MEASUREMENT_NOISE: r_reg <= cfg_data;
                    default:               ;
                endcase
            end
            if (load_out) begin
                estimate_reg <= x_new_reg;
                variance_reg <= p_new_reg;
                m_valid_reg  <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg  <= 1'b0;
            end
        end
    end

    // Working registers carry no reset; the sequencer decides when they load.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            z_reg  <= s_measurement;
            pm_reg <= pm_sat;
        end
        if (state_reg == S_PREP) begin
            den_reg  <= {1'b0, pm_reg} + {1'b0, r_reg};
            diff_reg <= (DATA_W+1)'(z_reg) - (DATA_W+1)'(estimate_reg);
        end
        // A zero denominator would make the divider return all ones.
        if (state_reg == S_DIV_WAIT && !div_status.busy) begin
            gain_reg <= (den_reg == '0) ? '0 : quotient;
        end
        if (state_reg == S_MUL_P) begin
            x_new_reg <= x_sum[DATA_W-1:0];
        end
        if (state_reg == S_UPDATE) begin
            p_new_reg <= rounded[DATA_W+15:16];
        end
        if (load_out) begin
            m_estimate_reg <= x_new_reg;
            m_gain_reg     <= gain_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_estimate = m_estimate_reg;
    assign m_gain     = m_gain_reg;

    // One word in work at a time: an accepted word closes the input side.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a word is in work");

    // The gain taken from the divider never exceeds one.
    a_gain_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DIV_WAIT && !div_status.busy && den_reg != '0
        |-> quotient <= GAIN_ONE)
        else $error("gain quotient above one");

    // The kept estimate only moves when a result word is loaded.
    a_state_with_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$stable(estimate_reg) |-> m_valid)
        else $error("estimate changed without a result word");

    // A finished result is never dropped while the receiver stalls.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !load_out)
        else $error("output register loaded while still held");

endmodule

`default_nettype wire
